// File: rtl/core/hpack_literal_header_encoder_unit_assert.svh
// Assertion helpers for the literal header encoder.
`ifndef HPACK_LITERAL_HEADER_ENCODER_UNIT_ASSERT_SVH
`define HPACK_LITERAL_HEADER_ENCODER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HLE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hle: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hle: next-cycle check failed");

`endif

// File: rtl/core/hle_pkg.sv
package hle_pkg;

    // Field widths of the channels.
    localparam int KIND_W = 2;
    localparam int LEN_W  = 22;
    localparam int CAP_W  = 24;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NAME  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VALUE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NEWBUF = 2'd3;

    localparam logic [CAP_W-1:0] CAP_RESET = 24'd16384;
    localparam logic [LEN_W-1:0] LEN_LIMIT = 22'd2097279;
    localparam logic [7:0] LIT_MARK = 8'h00;

    // Static-table names: length, code and text (first character leftmost).
    localparam int N_STATIC = 9;
    localparam int STATIC_MAX = 14;
    localparam logic [3:0] STATIC_LEN [N_STATIC] = '{
        4'd4, 4'd4, 4'd6, 4'd8, 4'd12, 4'd13, 4'd13, 4'd13, 4'd14};
    localparam logic [7:0] STATIC_CODE [N_STATIC] = '{
        8'h61, 8'h62, 8'h76, 8'h6e, 8'h5f, 8'h6c, 8'h51, 8'h58, 8'h5c};
    localparam logic [8*STATIC_MAX-1:0] STATIC_TEXT [N_STATIC] = '{
        "date", "etag", "server", "location", "content-type",
        "last-modified", "accept-ranges", "cache-control", "content-length"};

    // Command kinds between front and back end.
    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_PREFIX = 1'b1;

    typedef struct packed {
        logic             op;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic             eoh;
        logic             fail;
    } t_cmd;

    // Byte count of a 7-bit-prefix length; zero when it cannot be coded.
    function automatic logic [2:0] prefix_bytes(input logic [LEN_W-1:0] len);
        logic [2:0] n;
        if (len < 22'd127) begin
            n = 3'd1;
        end else if (len < 22'd255) begin
            n = 3'd2;
        end else if (len < 22'd16511) begin
            n = 3'd3;
        end else if (len < LEN_LIMIT) begin
            n = 3'd4;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

endpackage

// File: rtl/core/hle_in_if.sv
interface hle_in_if import hle_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  name_length;
    logic [LEN_W-1:0]  value_length;
    logic [7:0]        data_byte;
    logic [CAP_W-1:0]  start_fill;

    modport source (output valid, kind, name_length, value_length, data_byte, start_fill,
                    input ready);
    modport sink (input valid, kind, name_length, value_length, data_byte, start_fill,
                  output ready);
endinterface

// File: rtl/core/hle_out_if.sv
interface hle_out_if import hle_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [7:0]       out_byte;
    logic             end_of_header;
    logic             failed;
    logic [CAP_W-1:0] fill_after;

    modport source (output valid, out_byte, end_of_header, failed, fill_after, input ready);
    modport sink (input valid, out_byte, end_of_header, failed, fill_after, output ready);
endinterface

// File: rtl/core/hle_cfg_if.sv
interface hle_cfg_if import hle_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] buffer_capacity;

    modport source (output valid, buffer_capacity, input ready);
    modport sink (input valid, buffer_capacity, output ready);
endinterface

// File: rtl/core/hle_fifo.sv
module hle_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_room,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_room  = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// File: rtl/core/hle_front.sv
module hle_front import hle_pkg::*; #(
    parameter int NAME_STORE_DEPTH = 14,
    parameter int FILL_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    hle_in_if.sink               i_in,
    hle_cfg_if.sink              i_cfg,
    output logic                 o_push,
    output t_cmd                 o_cmd,
    output logic [FILL_BITS-1:0] o_fill,
    input  logic                 i_room
);
    localparam int IDX_W  = $clog2(NAME_STORE_DEPTH);
    localparam int NEED_W = ((FILL_BITS > CAP_W) ? FILL_BITS : CAP_W) + 2;

    // Header phases.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PASS = 2'd1;
    localparam logic [1:0] PH_BUF  = 2'd2;
    localparam logic [1:0] PH_VAL  = 2'd3;

    // Sequencer steps; all but ST_ACCEPT issue one command whenever the queue has room.
    localparam logic [2:0] ST_ACCEPT = 3'd0;
    localparam logic [2:0] ST_NAMEPFX = 3'd1;
    localparam logic [2:0] ST_VALPFX = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_LITLEN = 3'd4;
    localparam logic [2:0] ST_NAMEBYTES = 3'd5;

    logic [CAP_W-1:0]     r_cap;
    logic [FILL_BITS-1:0] r_fill, n_fill;
    logic [LEN_W-1:0]     r_name_left, n_name_left;
    logic [LEN_W-1:0]     r_value_left, n_value_left;
    logic [LEN_W-1:0]     r_pend, n_pend;
    logic [3:0]           r_count, n_count;
    logic [1:0]           r_phase, n_phase;
    logic                 r_drop, n_drop;
    logic [2:0]           r_seq, n_seq;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [7:0]           r_store [NAME_STORE_DEPTH];

    logic                 w_acc;
    logic                 w_store_we;
    logic [LEN_W-1:0]     w_nl, w_vl;
    logic [2:0]           w_bn, w_bv;
    logic [NEED_W-1:0]    w_need_lit, w_need_st;
    logic                 w_ok_lit, w_ok_st;
    logic                 w_cand;
    logic                 w_hit;
    logic [7:0]           w_code;
    logic                 w_pos_ok;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_seq == ST_ACCEPT) && i_room;
    assign w_acc       = i_in.valid && i_in.ready;

    // Room checks: on a header start they use the request lengths,
    // during a flush the buffered name count and the saved value length.
    assign w_nl = (r_seq == ST_FLUSH) ? LEN_W'(r_count) : i_in.name_length;
    assign w_vl = (r_seq == ST_FLUSH) ? r_pend : i_in.value_length;
    assign w_bn = prefix_bytes(w_nl);
    assign w_bv = prefix_bytes(w_vl);
    assign w_need_lit = NEED_W'(r_fill) + NEED_W'(1) + NEED_W'(w_bn) + NEED_W'(w_nl)
                      + NEED_W'(w_bv) + NEED_W'(w_vl);
    assign w_need_st  = NEED_W'(r_fill) + NEED_W'(1) + NEED_W'(w_bv) + NEED_W'(w_vl);
    assign w_ok_lit = (w_bn != 3'd0) && (w_bv != 3'd0) && (w_need_lit <= NEED_W'(r_cap));
    assign w_ok_st  = (w_bv != 3'd0) && (w_need_st <= NEED_W'(r_cap));

    // Name lengths that may belong to a static-table entry.
    always_comb begin
        w_cand = 1'b0;
        for (int i = 0; i < N_STATIC; i++) begin
            if (i_in.name_length == LEN_W'(STATIC_LEN[i])) begin
                w_cand = 1'b1;
            end
        end
    end

    // Exact match of the buffered name against the static names.
    always_comb begin
        w_hit  = 1'b0;
        w_code = LIT_MARK;
        for (int i = N_STATIC - 1; i >= 0; i--) begin
            w_pos_ok = (r_count == STATIC_LEN[i]);
            for (int p = 0; p < STATIC_MAX; p++) begin
                if (p < int'(STATIC_LEN[i]) && p < NAME_STORE_DEPTH) begin
                    if (r_store[p] != STATIC_TEXT[i][8*(int'(STATIC_LEN[i])-1-p) +: 8]) begin
                        w_pos_ok = 1'b0;
                    end
                end
            end
            if (w_pos_ok) begin
                w_hit  = 1'b1;
                w_code = STATIC_CODE[i];
            end
        end
    end

    // Request handling and command sequencing.
    always_comb begin
        n_fill = r_fill;
        n_name_left = r_name_left;
        n_value_left = r_value_left;
        n_pend = r_pend;
        n_count = r_count;
        n_phase = r_phase;
        n_drop = r_drop;
        n_seq = r_seq;
        n_idx = r_idx;
        w_store_we = 1'b0;
        o_push = 1'b0;
        o_cmd.op = OP_BYTE;
        o_cmd.data = 8'd0;
        o_cmd.len = '0;
        o_cmd.eoh = 1'b0;
        o_cmd.fail = 1'b0;
        case (r_seq)
            ST_ACCEPT: begin
                if (w_acc) begin
                    case (i_in.kind)
                        KIND_START: begin
                            n_drop = 1'b0;
                            n_count = '0;
                            n_name_left = i_in.name_length;
                            n_value_left = i_in.value_length;
                            n_pend = i_in.value_length;
                            if (w_cand) begin
                                n_phase = PH_BUF;
                            end else if (w_ok_lit) begin
                                n_fill = FILL_BITS'(w_need_lit);
                                o_push = 1'b1;
                                o_cmd.data = LIT_MARK;
                                n_phase = PH_PASS;
                                n_seq = ST_NAMEPFX;
                            end else begin
                                o_push = 1'b1;
                                o_cmd.eoh = 1'b1;
                                o_cmd.fail = 1'b1;
                                if (i_in.name_length != '0) begin
                                    n_phase = PH_PASS;
                                    n_drop = 1'b1;
                                end else if (i_in.value_length != '0) begin
                                    n_phase = PH_VAL;
                                    n_drop = 1'b1;
                                end else begin
                                    n_phase = PH_IDLE;
                                end
                            end
                        end
                        KIND_NAME: begin
                            if (r_phase == PH_PASS) begin
                                o_push = !r_drop;
                                o_cmd.data = i_in.data_byte;
                                n_name_left = r_name_left - 1'b1;
                                if (r_name_left == LEN_W'(1)) begin
                                    if (r_drop) begin
                                        n_phase = (r_value_left != '0) ? PH_VAL : PH_IDLE;
                                        n_drop = (r_value_left != '0);
                                    end else begin
                                        n_seq = ST_VALPFX;
                                    end
                                end
                            end else if (r_phase == PH_BUF) begin
                                w_store_we = (32'(r_count) < NAME_STORE_DEPTH);
                                n_count = r_count + 1'b1;
                                n_name_left = r_name_left - 1'b1;
                                if (r_name_left == LEN_W'(1)) begin
                                    n_seq = ST_FLUSH;
                                end
                            end
                        end
                        KIND_VALUE: begin
                            if (r_phase == PH_VAL) begin
                                o_push = !r_drop;
                                o_cmd.data = i_in.data_byte;
                                o_cmd.eoh = (r_value_left == LEN_W'(1));
                                n_value_left = r_value_left - 1'b1;
                                if (r_value_left == LEN_W'(1)) begin
                                    n_drop = 1'b0;
                                    n_phase = PH_IDLE;
                                end
                            end
                        end
                        default: begin
                            n_fill = FILL_BITS'(i_in.start_fill);
                            n_phase = PH_IDLE;
                            n_drop = 1'b0;
                            n_name_left = '0;
                            n_value_left = '0;
                            n_count = '0;
                        end
                    endcase
                end
            end
            ST_NAMEPFX: begin
                if (i_room) begin
                    o_push = 1'b1;
                    o_cmd.op = OP_PREFIX;
                    o_cmd.len = r_name_left;
                    n_seq = (r_name_left == '0) ? ST_VALPFX : ST_ACCEPT;
                end
            end
            ST_VALPFX: begin
                if (i_room) begin
                    o_push = 1'b1;
                    o_cmd.op = OP_PREFIX;
                    o_cmd.len = r_pend;
                    o_cmd.eoh = (r_value_left == '0);
                    n_phase = (r_value_left != '0) ? PH_VAL : PH_IDLE;
                    n_seq = ST_ACCEPT;
                end
            end
            ST_FLUSH: begin
                if (i_room) begin
                    o_push = 1'b1;
                    if (w_hit && w_ok_st) begin
                        n_fill = FILL_BITS'(w_need_st);
                        o_cmd.data = w_code;
                        n_seq = ST_VALPFX;
                    end else if (!w_hit && w_ok_lit) begin
                        n_fill = FILL_BITS'(w_need_lit);
                        o_cmd.data = LIT_MARK;
                        n_seq = ST_LITLEN;
                    end else begin
                        // Header does not fit: one failed result, rest swallowed.
                        o_cmd.eoh = 1'b1;
                        o_cmd.fail = 1'b1;
                        n_phase = (r_value_left != '0) ? PH_VAL : PH_IDLE;
                        n_drop = (r_value_left != '0);
                        n_seq = ST_ACCEPT;
                    end
                end
            end
            ST_LITLEN: begin
                if (i_room) begin
                    o_push = 1'b1;
                    o_cmd.op = OP_PREFIX;
                    o_cmd.len = LEN_W'(r_count);
                    n_idx = '0;
                    n_seq = ST_NAMEBYTES;
                end
            end
            ST_NAMEBYTES: begin
                if (i_room) begin
                    o_push = 1'b1;
                    o_cmd.data = r_store[r_idx];
                    n_idx = r_idx + 1'b1;
                    if (5'(r_idx) == 5'(r_count) - 5'd1) begin
                        n_seq = ST_VALPFX;
                    end
                end
            end
            default: begin
                n_seq = ST_ACCEPT;
            end
        endcase
    end

    assign o_fill = n_fill;

    // Name buffer.
    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_store[r_count[IDX_W-1:0]] <= i_in.data_byte;
        end
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
            r_fill <= '0;
            r_name_left <= '0;
            r_value_left <= '0;
            r_pend <= '0;
            r_count <= '0;
            r_phase <= PH_IDLE;
            r_drop <= 1'b0;
            r_seq <= ST_ACCEPT;
            r_idx <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_cap <= i_cfg.buffer_capacity;
            end
            r_fill <= n_fill;
            r_name_left <= n_name_left;
            r_value_left <= n_value_left;
            r_pend <= n_pend;
            r_count <= n_count;
            r_phase <= n_phase;
            r_drop <= n_drop;
            r_seq <= n_seq;
            r_idx <= n_idx;
        end
    end
endmodule

// File: rtl/core/hle_back.sv
module hle_back import hle_pkg::*; #(
    parameter int FILL_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_cmd                 i_cmd,
    input  logic [FILL_BITS-1:0] i_fill,
    output logic                 o_pop,
    hle_out_if.source            o_out
);
    logic                 r_act;
    t_cmd                 r_cmd;
    logic                 r_first;
    logic [FILL_BITS-1:0] r_cfill;
    logic                 r_ov;
    logic [7:0]           r_byte;
    logic                 r_eoh, r_fail;
    logic [FILL_BITS-1:0] r_ofill;

    t_cmd                 w_src;
    logic                 w_first;
    logic [FILL_BITS-1:0] w_fill;
    logic [7:0]           w_byte;
    logic [LEN_W-1:0]     w_rem;
    logic                 w_last;
    logic                 w_adv, w_go;

    assign w_src   = r_act ? r_cmd : i_cmd;
    assign w_first = r_act ? r_first : 1'b1;
    assign w_fill  = r_act ? r_cfill : i_fill;
    assign w_adv   = !r_ov || o_out.ready;
    assign w_go    = w_adv && (r_act || i_valid);
    assign o_pop   = w_adv && !r_act && i_valid;

    // Next byte of the current command; prefixes go out one group per cycle unless stalled.
    always_comb begin
        w_byte = w_src.data;
        w_rem  = w_src.len;
        w_last = 1'b1;
        if (w_src.op == OP_PREFIX) begin
            if (w_first) begin
                if (w_src.len < 22'd127) begin
                    w_byte = w_src.len[7:0];
                end else begin
                    w_byte = 8'd127;
                    w_rem  = w_src.len - 22'd127;
                    w_last = 1'b0;
                end
            end else if (w_src.len >= 22'd128) begin
                w_byte = {1'b1, w_src.len[6:0]};
                w_rem  = w_src.len >> 7;
                w_last = 1'b0;
            end else begin
                w_byte = w_src.len[7:0];
            end
        end
    end

    // Active command and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_ov  <= 1'b0;
        end else if (w_go) begin
            r_ov  <= 1'b1;
            r_act <= !w_last;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_byte  <= w_byte;
            r_eoh   <= w_src.eoh && w_last;
            r_fail  <= w_src.fail && (w_src.op == OP_BYTE);
            r_ofill <= w_fill;
            r_cmd   <= {w_src.op, w_src.data, w_rem, w_src.eoh, w_src.fail};
            r_first <= 1'b0;
            r_cfill <= w_fill;
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.out_byte      = r_byte;
    assign o_out.end_of_header = r_eoh;
    assign o_out.failed        = r_fail;
    assign o_out.fill_after    = CAP_W'(r_ofill);
endmodule

// File: rtl/core/hpack_literal_header_encoder_unit.sv
// Channel   Dir  Contents
// i_in      in   kind, name_length, value_length, data_byte, start_fill
// i_cfg     in   buffer_capacity (always ready)
// o_out     out  out_byte, end_of_header, failed, fill_after
//
// Requests are taken in ST_ACCEPT while the queue has room. A literal header start
// adds ST_NAMEPFX (and ST_VALPFX with an empty name), the last passed-through name
// byte adds ST_VALPFX. A complete buffered name adds ST_FLUSH, then ST_VALPFX on a
// static match, nothing when it does not fit, or ST_LITLEN, ST_NAMEBYTES, ST_VALPFX
// for a literal name. The back end sends one byte per cycle unless the receiver stalls.
// Synchronous active-low reset clears control state and sets capacity to 16384;
// a command queue of QUEUE_DEPTH entries lets either side stall alone.
`include "hpack_literal_header_encoder_unit_assert.svh"
module hpack_literal_header_encoder_unit import hle_pkg::*; #(
    parameter int NAME_STORE_DEPTH = 14,
    parameter int FILL_BITS = 24,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hle_in_if.sink    i_in,
    hle_cfg_if.sink   i_cfg,
    hle_out_if.source o_out
);
    localparam int Q_W = $bits(t_cmd) + FILL_BITS;

    logic                 w_push, w_q_ready, w_q_valid, w_pop;
    t_cmd                 w_cmd, w_q_cmd;
    logic [FILL_BITS-1:0] w_fill, w_q_fill;
    logic [Q_W-1:0]       w_q_data;

    // Front end: accepts requests, checks room, issues commands.
    hle_front #(
        .NAME_STORE_DEPTH(NAME_STORE_DEPTH),
        .FILL_BITS(FILL_BITS)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(i_in),
        .i_cfg(i_cfg),
        .o_push(w_push),
        .o_cmd(w_cmd),
        .o_fill(w_fill),
        .i_room(w_q_ready)
    );

    // Command queue.
    hle_fifo #(
        .WIDTH(Q_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(w_push),
        .i_data({w_cmd, w_fill}),
        .o_room(w_q_ready),
        .o_valid(w_q_valid),
        .o_data(w_q_data),
        .i_pop(w_pop)
    );

    assign w_q_cmd  = w_q_data[Q_W-1:FILL_BITS];
    assign w_q_fill = w_q_data[FILL_BITS-1:0];

    // Back end: expands commands into output bytes.
    hle_back #(
        .FILL_BITS(FILL_BITS)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_q_valid),
        .i_cmd(w_q_cmd),
        .i_fill(w_q_fill),
        .o_pop(w_pop),
        .o_out(o_out)
    );

    // A failed result is a lone zero byte closing its header.
    `HLE_ASSERT_IMPLY(a_fail_shape, i_clk, i_rst_n, o_out.valid && o_out.failed, o_out.end_of_header && (o_out.out_byte == 8'd0))
    // A request is only taken while the queue has room.
    `HLE_ASSERT_IMPLY(a_accept_room, i_clk, i_rst_n, i_in.valid && i_in.ready, w_q_ready)
    // A command pushed into an empty queue is visible to the back end next cycle.
    `HLE_ASSERT_NEXT(a_push_seen, i_clk, i_rst_n, w_push && !w_q_valid, w_q_valid)
endmodule

// File: test/hpack_literal_header_encoder_unit_tb.sv
`timescale 1ns / 100ps

module hpack_literal_header_encoder_unit_tb;
    import hle_pkg::*;

    // Encoder progress through one header.
    typedef enum logic [1:0] {
        ENC_IDLE,
        ENC_NAME_PASS,
        ENC_NAME_BUF,
        ENC_VALUE
    } t_enc_phase;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  nlen;
        logic [LEN_W-1:0]  vlen;
        logic [7:0]        data;
        logic [CAP_W-1:0]  sfill;
    } t_request;

    typedef struct {
        logic [7:0]       obyte;
        logic             eoh;
        logic             fail;
        logic [CAP_W-1:0] fill;
    } t_encoded;

    localparam int ENC_STORE_DEPTH = 14;
    localparam longint unsigned CODE_LIMIT = 2097279;

    logic i_clk;
    logic i_rst_n;

    hle_in_if  in_ch ();
    hle_cfg_if cfg_ch ();
    hle_out_if out_ch ();

    hpack_literal_header_encoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    t_request request_q[$];
    t_encoded encoded_q[$];
    int mismatches = 0;
    int accepted_requests = 0;

    // Shadow state of the encoder.
    logic [CAP_W-1:0] shadow_capacity;
    logic [CAP_W-1:0] shadow_fill;
    longint unsigned  name_remaining;
    longint unsigned  value_remaining;
    longint unsigned  value_length_held;
    logic [7:0]       name_bytes [ENC_STORE_DEPTH];
    int               name_seen;
    t_enc_phase       enc_phase;
    bit               swallowing;
    int               step_results;

    string known_text [N_STATIC] = '{"date", "etag", "server", "location", "content-type",
        "last-modified", "accept-ranges", "cache-control", "content-length"};

    // Clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int length_prefix_size(longint unsigned len);
        if (len < 127) return 1;
        if (len < 255) return 2;
        if (len < 16511) return 3;
        if (len < CODE_LIMIT) return 4;
        return 0;
    endfunction

    function void push_encoded(logic [7:0] b, logic eoh, logic fail);
        encoded_q.push_back('{b, eoh, fail, shadow_fill});
        step_results++;
    endfunction

    function void close_header();
        if (step_results > 0) encoded_q[encoded_q.size()-1].eoh = 1'b1;
    endfunction

    function void push_length(longint unsigned len);
        longint unsigned c;
        if (len < 127) begin
            push_encoded(len[7:0], 1'b0, 1'b0);
        end else begin
            push_encoded(8'd127, 1'b0, 1'b0);
            for (c = len - 127; c >= 128; c = c >> 7)
                push_encoded({1'b1, c[6:0]}, 1'b0, 1'b0);
            push_encoded(c[7:0], 1'b0, 1'b0);
        end
    endfunction

    function void reject_header();
        push_encoded(8'h00, 1'b1, 1'b1);
        swallowing = 1'b1;
    endfunction

    // After a rejection the rest of the header is swallowed.
    function void skip_to_value();
        enc_phase = (value_remaining != 0) ? ENC_VALUE : ENC_IDLE;
        if (value_remaining == 0) swallowing = 1'b0;
    endfunction

    function void encode_value_prefix();
        push_length(value_length_held);
        if (value_remaining == 0) begin
            close_header();
            enc_phase = ENC_IDLE;
        end else begin
            enc_phase = ENC_VALUE;
        end
    endfunction

    function bit room_for_literal(longint unsigned nl, longint unsigned vl);
        longint unsigned need;
        int bn;
        int bv;
        bn = length_prefix_size(nl);
        bv = length_prefix_size(vl);
        if (bn == 0 || bv == 0) return 1'b0;
        need = shadow_fill + 1 + bn + nl + bv + vl;
        if (need > shadow_capacity) return 1'b0;
        shadow_fill = need[CAP_W-1:0];
        return 1'b1;
    endfunction

    function bit static_length(longint unsigned nl);
        for (int i = 0; i < N_STATIC; i++)
            if (STATIC_LEN[i] == nl) return 1'b1;
        return 1'b0;
    endfunction

    // Buffered name complete: match against the static names, else code it literally.
    function void flush_buffered_name();
        int hit;
        int len;
        bit same;
        longint unsigned need;
        int bv;
        hit = -1;
        for (int i = 0; i < N_STATIC && hit < 0; i++) begin
            len = STATIC_LEN[i];
            if (len == name_seen) begin
                same = 1'b1;
                for (int k = 0; k < len; k++)
                    if (STATIC_TEXT[i][8*(len-1-k) +: 8] != name_bytes[k]) same = 1'b0;
                if (same) hit = i;
            end
        end
        if (hit >= 0) begin
            bv = length_prefix_size(value_length_held);
            need = shadow_fill + 1 + bv + value_length_held;
            if (bv == 0 || need > shadow_capacity) begin
                reject_header();
                skip_to_value();
                return;
            end
            shadow_fill = need[CAP_W-1:0];
            push_encoded(STATIC_CODE[hit], 1'b0, 1'b0);
        end else begin
            if (!room_for_literal(name_seen, value_length_held)) begin
                reject_header();
                skip_to_value();
                return;
            end
            push_encoded(LIT_MARK, 1'b0, 1'b0);
            push_length(name_seen);
            for (int k = 0; k < name_seen && k < ENC_STORE_DEPTH; k++)
                push_encoded(name_bytes[k], 1'b0, 1'b0);
        end
        encode_value_prefix();
    endfunction

    // Works out the encoded bytes caused by one accepted request.
    function void encode_request(t_request r);
        step_results = 0;
        case (r.kind)
            KIND_START: begin
                swallowing = 1'b0;
                name_seen = 0;
                name_remaining = r.nlen;
                value_remaining = r.vlen;
                value_length_held = r.vlen;
                if (static_length(r.nlen)) begin
                    enc_phase = ENC_NAME_BUF;
                end else if (!room_for_literal(r.nlen, r.vlen)) begin
                    reject_header();
                    if (r.nlen != 0) enc_phase = ENC_NAME_PASS;
                    else skip_to_value();
                end else begin
                    push_encoded(LIT_MARK, 1'b0, 1'b0);
                    push_length(r.nlen);
                    if (r.nlen == 0) encode_value_prefix();
                    else enc_phase = ENC_NAME_PASS;
                end
            end
            KIND_NAME: begin
                if (enc_phase == ENC_NAME_PASS) begin
                    if (!swallowing) push_encoded(r.data, 1'b0, 1'b0);
                    name_remaining--;
                    if (name_remaining == 0) begin
                        if (swallowing) skip_to_value();
                        else encode_value_prefix();
                    end
                end else if (enc_phase == ENC_NAME_BUF) begin
                    if (name_seen < ENC_STORE_DEPTH) name_bytes[name_seen] = r.data;
                    name_seen = (name_seen + 1) & 15;
                    name_remaining--;
                    if (name_remaining == 0) flush_buffered_name();
                end
            end
            KIND_VALUE: begin
                if (enc_phase == ENC_VALUE) begin
                    if (!swallowing) push_encoded(r.data, 1'b0, 1'b0);
                    value_remaining--;
                    if (value_remaining == 0) begin
                        if (!swallowing) close_header();
                        swallowing = 1'b0;
                        enc_phase = ENC_IDLE;
                    end
                end
            end
            default: begin
                shadow_fill = r.sfill;
                enc_phase = ENC_IDLE;
                swallowing = 1'b0;
                name_remaining = 0;
                value_remaining = 0;
                name_seen = 0;
            end
        endcase
    endfunction

    // Request driver: bursts of random length separated by random gaps.
    int burst_left = 4;
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_request r;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (request_q.size() > 0) begin
                r = request_q.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.kind <= r.kind;
                in_ch.name_length <= r.nlen;
                in_ch.value_length <= r.vlen;
                in_ch.data_byte <= r.data;
                in_ch.start_fill <= r.sfill;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // One long hold of the receiver, counted on its own, to back up the input.
    int hold_cycles = 0;
    bit held_once = 1'b0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!held_once && accepted_requests >= 40) begin
                held_once = 1'b1;
                hold_cycles = 300;
            end else if (hold_cycles > 0) begin
                hold_cycles--;
            end
        end
    end

    // Receiver: a changing stall pattern, off while the long hold runs.
    int ready_mode = 0;
    int mode_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (mode_cycles == 0) begin
                ready_mode = $urandom_range(0, 2);
                mode_cycles = $urandom_range(20, 80);
            end
            mode_cycles--;
            if (hold_cycles > 0) begin
                out_ch.ready <= 1'b0;
            end else begin
                case (ready_mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= $urandom_range(0, 1);
                    default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Monitor: predict on accepted requests, then check accepted output bytes.
    always @(posedge i_clk) begin
        t_request r;
        t_encoded w;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                r = '{in_ch.kind, in_ch.name_length, in_ch.value_length,
                      in_ch.data_byte, in_ch.start_fill};
                encode_request(r);
                accepted_requests++;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (encoded_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output byte %h eoh %b fail %b fill %0d",
                                 out_ch.out_byte, out_ch.end_of_header, out_ch.failed,
                                 out_ch.fill_after);
                end else begin
                    w = encoded_q.pop_front();
                    if (out_ch.out_byte !== w.obyte || out_ch.end_of_header !== w.eoh ||
                        out_ch.failed !== w.fail || out_ch.fill_after !== w.fill) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h/%b/%b/%0d got %h/%b/%b/%0d",
                                     w.obyte, w.eoh, w.fail, w.fill, out_ch.out_byte,
                                     out_ch.end_of_header, out_ch.failed, out_ch.fill_after);
                    end
                end
            end
        end
    end

    function void queue_request(logic [KIND_W-1:0] k, longint unsigned nl, longint unsigned vl,
                                logic [7:0] d, logic [CAP_W-1:0] sf);
        request_q.push_back('{k, nl[LEN_W-1:0], vl[LEN_W-1:0], d, sf});
    endfunction

    // One header; nsend and vsend cut it short when below the lengths.
    function void queue_header(string nm, longint unsigned nl, longint unsigned vl,
                               int nsend, int vsend);
        logic [7:0] b;
        queue_request(KIND_START, nl, vl, $urandom, $urandom);
        for (int i = 0; i < nsend; i++) begin
            b = (i < nm.len()) ? nm[i] : $urandom_range(0, 255);
            queue_request(KIND_NAME, $urandom, $urandom, b, $urandom);
        end
        for (int i = 0; i < vsend; i++)
            queue_request(KIND_VALUE, $urandom, $urandom, $urandom_range(0, 255), $urandom);
    endfunction

    function void queue_random_header();
        string nm;
        int nl;
        int vl;
        int pick;
        pick = $urandom_range(0, 99);
        vl = ($urandom_range(0, 9) == 0) ? $urandom_range(120, 260) : $urandom_range(0, 12);
        if (pick < 45) begin
            nm = known_text[$urandom_range(0, N_STATIC-1)];
            if ($urandom_range(0, 4) == 0) nm[$urandom_range(0, nm.len()-1)] = "X";
            nl = nm.len();
        end else begin
            nm = "";
            nl = ($urandom_range(0, 14) == 0) ? $urandom_range(120, 135) : $urandom_range(0, 16);
        end
        if (pick >= 92) begin
            // Broken header: cut short, then abandoned by what follows.
            queue_header(nm, nl, vl, $urandom_range(0, nl), 0);
        end else if (nl > 16 || vl > 12) begin
            // Long header: start, name (three bytes if long) and three value bytes.
            queue_header(nm, nl, vl, (nl > 16) ? 3 : nl, 3);
        end else begin
            queue_header(nm, nl, vl, nl, vl);
        end
        if ($urandom_range(0, 9) == 0)
            queue_request(KIND_VALUE, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 9) == 0)
            queue_request(KIND_NEWBUF, $urandom, $urandom, $urandom,
                          ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 100));
    endfunction

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.buffer_capacity <= cap;
        forever begin
            @(posedge i_clk);
            if (cfg_ch.ready) break;
        end
        shadow_capacity = cap;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (request_q.size() > 0 || in_ch.valid || encoded_q.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic run_random(int count);
        int target;
        target = accepted_requests + request_q.size() + count;
        while (accepted_requests + request_q.size() < target) queue_random_header();
        wait_idle();
    endtask

    initial begin
        logic [CAP_W-1:0] caps [4] = '{24'd1, 24'd60, 24'd300, CAP_RESET};
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_START;
        in_ch.name_length = '0;
        in_ch.value_length = '0;
        in_ch.data_byte = '0;
        in_ch.start_fill = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.buffer_capacity = '0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        shadow_capacity = CAP_RESET;
        shadow_fill = '0;
        name_remaining = 0;
        value_remaining = 0;
        value_length_held = 0;
        name_seen = 0;
        enc_phase = ENC_IDLE;
        swallowing = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed headers at the largest capacity.
        write_capacity(24'hFFFFFF);
        queue_header("date", 4, 1, 4, 1);
        queue_header("content-length", 14, 0, 14, 0);
        queue_header("", 0, 0, 0, 0);
        queue_header("Date", 4, 2, 4, 2);
        // Long lengths give multi-byte prefixes; the headers are abandoned early.
        queue_header("", 2, 300, 2, 2);
        queue_header("", 130, 1, 3, 1);
        queue_request(KIND_NAME, 0, 0, 8'hFF, 0);
        queue_request(KIND_VALUE, 0, 0, 8'h00, 0);
        // Uncodeable lengths fail, and the next start abandons the header.
        queue_header("", 22'h3FFFFF, 22'h3FFFFF, 3, 0);
        queue_header("etag", 4, CODE_LIMIT, 4, 2);
        // Longest codeable value, abandoned by a new buffer.
        queue_header("", 0, CODE_LIMIT - 1, 0, 2);
        queue_request(KIND_NEWBUF, 0, 0, 0, 24'hFFFFF0);
        queue_header("server", 6, 3, 6, 3);
        queue_request(KIND_NEWBUF, 0, 0, 0, 24'h000000);
        queue_header("", 3, 16600, 3, 1);
        queue_request(KIND_NEWBUF, 0, 0, 0, 24'd0);
        wait_idle();
        run_random(10);

        // Further capacities, each with a fresh buffer and random headers.
        foreach (caps[i]) begin
            write_capacity(caps[i]);
            queue_request(KIND_NEWBUF, 0, 0, 0, 24'd0);
            run_random(8);
        end

        wait_idle();
        if (encoded_q.size() != 0) mismatches++;
        if (mismatches == 0)
            $display("** hpack_literal_header_encoder_unit: PASSED **");
        else
            $display("** hpack_literal_header_encoder_unit: FAILED **");
        $finish;
    end

    // Run limit.
    initial begin
        #5000000;
        $display("** hpack_literal_header_encoder_unit: FAILED **");
        $finish;
    end

endmodule
